// File: hw/rtl/sia_pkg.sv
// ----------------------------------------------------------------------------
// sia_pkg: shared types and codes for the shift/insert array
// Request codes and the command that the top level broadcasts to every cell.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int WORD_W  = 32;
  localparam int IDX_W   = 4;
  localparam int SIZE_W  = 5;
  localparam int REQ_W   = 2;

  localparam logic [REQ_W-1:0] REQ_READ      = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_OVERWRITE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE    = 2'd3;

  typedef struct packed {
    logic                     update;
    logic [REQ_W-1:0]         op;
    logic [IDX_W-1:0]         idx;
    logic signed [WORD_W-1:0] val;
    logic [SIZE_W-1:0]        size;
  } sia_cmd_t;

endpackage

// File: hw/rtl/sia_cell.sv
// ----------------------------------------------------------------------------
// sia_cell: one storage cell of the shift/insert array
// Holds one word and picks its next value from itself, its neighbors or the
// broadcast write value, depending on the request and its own position.
// ----------------------------------------------------------------------------
module sia_cell import sia_pkg::*; #(
  parameter int CELL_ID = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sia_cmd_t                 cmd,
  input  logic signed [WORD_W-1:0] left_value,
  input  logic signed [WORD_W-1:0] right_value,
  output logic signed [WORD_W-1:0] value,
  output logic signed [WORD_W-1:0] sel_value
);

  localparam int CW = ($clog2(CELL_ID + 2) > SIZE_W + 1) ? $clog2(CELL_ID + 2) : SIZE_W + 1;
  localparam logic [CW-1:0] ID = CW'(CELL_ID);

  logic [CW-1:0]            idx_ext;
  logic [CW-1:0]            size_ext;
  logic                     at_idx;
  logic                     above_idx;
  logic                     in_use;
  logic                     is_last;
  logic signed [WORD_W-1:0] value_next;

  assign idx_ext   = {{(CW - IDX_W){1'b0}}, cmd.idx};
  assign size_ext  = {{(CW - SIZE_W){1'b0}}, cmd.size};
  assign at_idx    = (ID == idx_ext);
  assign above_idx = (ID > idx_ext);
  assign in_use    = (ID < size_ext);
  assign is_last   = ((ID + CW'(1)) == size_ext);

  always_comb begin
    value_next = value;
    unique case (cmd.op)
      REQ_READ: begin
        value_next = value;
      end
      REQ_INSERT: begin
        if (at_idx) begin
          value_next = cmd.val;
        end else if (above_idx && in_use) begin
          value_next = left_value;
        end
      end
      REQ_OVERWRITE: begin
        if (at_idx) begin
          value_next = cmd.val;
        end
      end
      default: begin
        if (is_last) begin
          value_next = '0;
        end else if ((at_idx || above_idx) && in_use) begin
          value_next = right_value;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (cmd.update) begin
      value <= value_next;
    end
  end

  assign sel_value = at_idx ? value : '0;

endmodule

// File: hw/rtl/shift_insert_array.sv
// ----------------------------------------------------------------------------
// shift_insert_array: array of signed words with insert and remove by shifting
// A row of cells that read, overwrite, insert with shift up, or remove with
// shift down, within the first used_size slots, capped at DEPTH.
// ----------------------------------------------------------------------------
// Every cell updates on the same clock edge: a request is accepted and its
// result appears in the output register on the next cycle, and one beat can be
// accepted every cycle while the output is taken.
// The result register lets a new beat in while a finished one waits if the
// consumer takes it in the same cycle. Cells reset to zero and used_size to 16.
module shift_insert_array import sia_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [REQ_W-1:0]         req_type,
  input  logic [IDX_W-1:0]         slot_index,
  input  logic signed [WORD_W-1:0] write_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] read_value,
  output logic                     index_error,
  input  logic                     cfg_write_en,
  input  logic [SIZE_W-1:0]        cfg_write_data
);

  localparam int DW = ($clog2(DEPTH + 1) > SIZE_W) ? $clog2(DEPTH + 1) : SIZE_W + 1;
  localparam logic [DW-1:0] DEPTH_V = DW'(DEPTH);

  logic [SIZE_W-1:0]        used_size;
  logic [SIZE_W-1:0]        size_eff;
  logic                     accept;
  logic                     err;
  sia_cmd_t                 cmd;
  logic signed [WORD_W-1:0] cell_value [DEPTH];
  logic signed [WORD_W-1:0] cell_sel   [DEPTH];
  logic signed [WORD_W-1:0] rd_any;

  assign size_eff = ({{(DW - SIZE_W){1'b0}}, used_size} > DEPTH_V) ?
                    SIZE_W'(DEPTH_V) : used_size;
  assign err      = ({1'b0, slot_index} >= size_eff);
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign cmd.update = accept && !err;
  assign cmd.op     = req_type;
  assign cmd.idx    = slot_index;
  assign cmd.val    = write_value;
  assign cmd.size   = size_eff;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_v;
    logic signed [WORD_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_left
      assign left_v = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_right
      assign right_v = cell_value[i+1];
    end
    sia_cell #(
      .CELL_ID (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_value[i]),
      .sel_value   (cell_sel[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | cell_sel[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_size <= SIZE_W'(16);
    end else if (cfg_write_en) begin
      used_size <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      index_error <= err;
      read_value  <= (!err && (req_type == REQ_READ)) ? rd_any : '0;
    end
  end

endmodule

// File: dv/tb_shift_insert_array.sv
// ----------------------------------------------------------------------------
// tb_shift_insert_array: testbench for the shift/insert array
// Reads, overwrites, inserts and removes are sent as valid/ready beats and
// predicted on acceptance by a local array copy. Each output beat is checked
// against the oldest prediction. Directed cases cover field extremes, index
// errors and odd used sizes. Random traffic runs under several size settings
// and three idle regimes.
// ----------------------------------------------------------------------------
module tb_shift_insert_array import sia_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ARRAY_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic                     index_error;
  } slot_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [REQ_W-1:0]         req_type = REQ_READ;
  logic [IDX_W-1:0]         slot_index = '0;
  logic signed [WORD_W-1:0] write_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [WORD_W-1:0] read_value;
  logic                     index_error;
  logic                     cfg_write_en = 1'b0;
  logic [SIZE_W-1:0]        cfg_write_data = '0;

  logic signed [WORD_W-1:0] model_cells [ARRAY_DEPTH];
  logic [SIZE_W-1:0]        model_size;
  slot_result_t             pending_results [$];
  int                       mismatch_count = 0;
  int                       cycle_count = 0;
  int                       send_gap_pct = 0;
  int                       recv_gap_pct = 0;

  shift_insert_array #(.DEPTH(ARRAY_DEPTH)) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .slot_index     (slot_index),
    .write_value    (write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_value     (read_value),
    .index_error    (index_error),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_shift_insert_array NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_gap_pct);
  end

  function automatic int active_slots();
    return (model_size > ARRAY_DEPTH) ? ARRAY_DEPTH : int'(model_size);
  endfunction

  function automatic slot_result_t apply_request(input logic [REQ_W-1:0] op,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic signed [WORD_W-1:0] val);
    slot_result_t res;
    int           lim;
    int           i;
    lim = active_slots();
    res.read_value  = '0;
    res.index_error = 1'b0;
    if (int'(idx) >= lim) begin
      res.index_error = 1'b1;
      return res;
    end
    case (op)
      REQ_READ: begin
        res.read_value = model_cells[idx];
      end
      REQ_INSERT: begin
        for (i = lim - 1; i > int'(idx); i--) model_cells[i] = model_cells[i-1];
        model_cells[idx] = val;
      end
      REQ_OVERWRITE: begin
        model_cells[idx] = val;
      end
      default: begin
        for (i = int'(idx); i + 1 < lim; i++) model_cells[i] = model_cells[i+1];
        model_cells[lim-1] = '0;
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch %0s at cycle %0d: expected %h, got %h", what, cycle_count,
               want, got);
  endtask

  always @(posedge clk) begin : check_results
    slot_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", '0, read_value);
      end else begin
        want = pending_results.pop_front();
        if (read_value !== want.read_value)
          report_mismatch("read_value", want.read_value, read_value);
        if (index_error !== want.index_error)
          report_mismatch("index_error", 32'(want.index_error), 32'(index_error));
      end
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic signed [WORD_W-1:0] val);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= op;
    slot_index  <= idx;
    write_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_request(op, idx, val));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_used_size(input logic [SIZE_W-1:0] size);
    drain_results();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= size;
    @(posedge clk);
    model_size = size;
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(19))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random_batch(input int n_items);
    logic [REQ_W-1:0] op;
    logic [IDX_W-1:0] idx;
    int               lim;
    int               k;
    for (k = 0; k < n_items; k++) begin
      lim = active_slots();
      op  = REQ_W'($urandom_range(3));
      if (lim == 0 || $urandom_range(99) < 10)
        idx = IDX_W'($urandom_range(ARRAY_DEPTH - 1));
      else if (lim < ARRAY_DEPTH && $urandom_range(99) < 6)
        idx = IDX_W'($urandom_range(ARRAY_DEPTH - 1, lim));
      else
        idx = IDX_W'($urandom_range(lim - 1));
      send_request(op, idx, pick_value());
    end
  endtask

  task automatic test_basic_ops();
    send_request(REQ_READ, 4'd0, 32'sh1234_5678);
    send_request(REQ_OVERWRITE, 4'd0, 32'sh7FFF_FFFF);
    send_request(REQ_OVERWRITE, 4'd15, 32'sh8000_0000);
    send_request(REQ_INSERT, 4'd0, -32'sd1);
    send_request(REQ_READ, 4'd1, '0);
    send_request(REQ_READ, 4'd15, '0);
    send_request(REQ_INSERT, 4'd15, 32'sh5555_5555);
    send_request(REQ_REMOVE, 4'd0, -32'sd1);
    send_request(REQ_REMOVE, 4'd15, '0);
    send_request(REQ_READ, 4'd0, '0);
    send_request(REQ_READ, 4'd15, '0);
    send_request(REQ_OVERWRITE, 4'd7, 32'shAAAA_AAAA);
  endtask

  task automatic test_size_edges();
    set_used_size(5'd4);
    send_request(REQ_READ, 4'd4, '0);
    send_request(REQ_INSERT, 4'd15, 32'sh0BAD_F00D);
    send_request(REQ_REMOVE, 4'd3, '0);
    send_request(REQ_INSERT, 4'd2, 32'sh0F0F_0F0F);
    send_request(REQ_REMOVE, 4'd0, '0);
    set_used_size(5'd1);
    send_request(REQ_INSERT, 4'd0, 32'sh7FFF_FFFF);
    send_request(REQ_READ, 4'd0, '0);
    send_request(REQ_REMOVE, 4'd0, '0);
    send_request(REQ_OVERWRITE, 4'd1, -32'sd1);
    set_used_size(5'd0);
    send_request(REQ_READ, 4'd0, '0);
    send_request(REQ_OVERWRITE, 4'd0, 32'sh8000_0000);
    set_used_size(5'd31);
    send_request(REQ_READ, 4'd15, '0);
    set_used_size(5'd17);
    send_request(REQ_REMOVE, 4'd15, '0);
  endtask

  task automatic test_random_slow_receiver();
    send_gap_pct = 18;
    recv_gap_pct = 81;
    set_used_size(5'd16);
    run_random_batch(70);
    set_used_size(5'd1);
    run_random_batch(70);
    set_used_size(5'd7);
    run_random_batch(70);
    set_used_size(5'($urandom_range(1, ARRAY_DEPTH)));
    run_random_batch(70);
  endtask

  task automatic test_random_slow_sender();
    send_gap_pct = 81;
    recv_gap_pct = 18;
    set_used_size(5'd2);
    run_random_batch(70);
    set_used_size(5'd31);
    run_random_batch(70);
    set_used_size(5'd0);
    run_random_batch(20);
    set_used_size(5'd16);
    run_random_batch(90);
  endtask

  task automatic test_random_full_rate();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_used_size(5'd17);
    run_random_batch(70);
    set_used_size(5'($urandom_range(3, ARRAY_DEPTH - 1)));
    run_random_batch(70);
    set_used_size(5'd16);
    run_random_batch(70);
    set_used_size(5'd5);
    run_random_batch(70);
  endtask

  initial begin
    foreach (model_cells[i]) model_cells[i] = '0;
    model_size = 5'd16;
    send_gap_pct = 18;
    recv_gap_pct = 81;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_size_edges();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_full_rate();
    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_shift_insert_array OK");
    end else begin
      $display("tb_shift_insert_array NOT OK");
    end
    $finish;
  end

endmodule
